// ===== rtl/hts_pkg.sv =====
package hts_pkg;

    // Field widths
    localparam int POS_W   = 24;
    localparam int TIME_W  = 16;
    localparam int SPEED_W = 16;

    // Datapath: Q11.12 difference scaled by 2^GUARD plus CORDIC growth
    localparam int GUARD = 8;
    localparam int CW    = 36;

    // Product and step-length widths
    localparam int PROD_W = SPEED_W + TIME_W;
    localparam int LEN_W  = PROD_W + 1 - 12;
    localparam int GAIN_W = 16;
    localparam int SCL_W  = LEN_W + GAIN_W;

    // CORDIC gain 0.6072529 in Q0.16
    localparam logic [GAIN_W-1:0] KGAIN = 16'd39797;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    // Operation codes carried in tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_VEC,
        ST_ROT,
        ST_FLIP,
        ST_ROUND,
        ST_OUT
    } hts_state_t;

    // Control for the shared micro-rotation unit
    typedef struct packed {
        logic [4:0] shift;
        logic       add_dir;
    } hts_uctl_t;

endpackage

// ===== rtl/hts_cordic_unit.sv =====
module hts_cordic_unit
    import hts_pkg::*;
(
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  hts_uctl_t            ctl,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out
);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    // Arithmetic shifts of the pre-iteration values
    assign xs = x_in >>> ctl.shift;
    assign ys = y_in >>> ctl.shift;

    // add_dir: x += y>>i, y -= x>>i; otherwise the opposite turn
    always_comb
    begin
        if (ctl.add_dir)
        begin
            x_out = x_in + ys;
            y_out = y_in - xs;
        end
        else
        begin
            x_out = x_in - ys;
            y_out = y_in + xs;
        end
    end

endmodule

// ===== rtl/homing_step_toward_target_core.sv =====
// Load goes from accept straight to the output state. Advance goes through prep,
// then, unless the target equals the position, the single shared micro-rotation
// unit runs the vectoring pass and then the rotation pass one iteration per cycle,
// then flip, round and output. Throughput: one item at a time; a new item is taken
// once the previous one has reached the output register. Reset (rst_n low, async)
// clears position to zero, speed to 1.0 and all handshake state.
module homing_step_toward_target_core
    import hts_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // speed, unsigned Q8.8
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // tdata: x_value[23:0], y_value[47:24], time_step[63:48]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // tuser: op[0]
    input  logic [0:0]  s_tuser,
    // tdata: out_x[23:0], out_y[47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    localparam int CNT_W = $clog2(CORDIC_ITERATIONS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_ITERATIONS - 1);
    localparam int RND_W = CW - GUARD;
    localparam int SUM_W = RND_W + 1;

    hts_state_t state_reg, state_next;

    logic [SPEED_W-1:0]          speed_reg;
    logic signed [POS_W-1:0]     pos_x_reg, pos_y_reg;
    logic signed [POS_W-1:0]     tgt_x_reg, tgt_y_reg;
    logic [TIME_W-1:0]           dt_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [SCL_W-GUARD-1:0]      gain_reg;
    logic signed [CW-1:0]        x_reg, y_reg;
    logic [CORDIC_ITERATIONS-1:0] dirs_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        flip_reg;
    logic                        out_valid_reg;
    logic signed [POS_W-1:0]     out_x_reg, out_y_reg;

    logic                        in_acc;
    logic                        iter_last;
    logic                        out_free;
    logic signed [CW-1:0]        dx, dy;
    logic                        zero_vec;
    logic [PROD_W:0]             len_sum;
    logic [SCL_W-1:0]            scaled;
    hts_uctl_t                   uctl;
    logic signed [CW-1:0]        ux, uy;
    logic signed [CW-1:0]        rnd_x, rnd_y;
    logic signed [SUM_W-1:0]     sum_x, sum_y;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign iter_last = (cnt_reg == CNT_LAST);
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_y_reg, out_x_reg};

    // Difference vector, extended to datapath width
    assign dx = CW'(tgt_x_reg) - CW'(pos_x_reg);
    assign dy = CW'(tgt_y_reg) - CW'(pos_y_reg);
    assign zero_vec = (dx == '0) && (dy == '0);

    // Step length and gain pre-scale
    assign len_sum = {1'b0, prod_reg} + (PROD_W + 1)'(2048);
    assign scaled  = SCL_W'(len_reg) * SCL_W'(KGAIN);

    // Shared micro-rotation unit; rotation pass inverts the stored direction
    always_comb
    begin
        uctl.shift   = 5'(cnt_reg);
        uctl.add_dir = (state_reg == ST_VEC) ? !y_reg[CW-1] : !dirs_reg[cnt_reg];
    end

    hts_cordic_unit u_unit
    (
        .x_in  (x_reg),
        .y_in  (y_reg),
        .ctl   (uctl),
        .x_out (ux),
        .y_out (uy)
    );

    // Round the guard bits away and add to the position
    assign rnd_x = (x_reg + CW'(1 << (GUARD - 1))) >>> GUARD;
    assign rnd_y = (y_reg + CW'(1 << (GUARD - 1))) >>> GUARD;
    assign sum_x = SUM_W'(pos_x_reg) + SUM_W'($signed(rnd_x[RND_W-1:0]));
    assign sum_y = SUM_W'(pos_y_reg) + SUM_W'($signed(rnd_y[RND_W-1:0]));

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(POS_MAX))
            sat_pos = POS_MAX;
        else if (v < SUM_W'(POS_MIN))
            sat_pos = POS_MIN;
        else
            sat_pos = v[POS_W-1:0];
    endfunction

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = (s_tuser[0] == OP_LOAD) ? ST_OUT : ST_PREP;
            ST_PREP:
                state_next = zero_vec ? ST_OUT : ST_VEC;
            ST_VEC:
                if (iter_last)
                    state_next = ST_ROT;
            ST_ROT:
                if (iter_last)
                    state_next = ST_FLIP;
            ST_FLIP:
                state_next = ST_ROUND;
            ST_ROUND:
                state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            speed_reg     <= SPEED_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                speed_reg <= cfg_data;
            // Position update
            if (in_acc && s_tuser[0] == OP_LOAD)
            begin
                pos_x_reg <= s_tdata[23:0];
                pos_y_reg <= s_tdata[47:24];
            end
            else if (state_reg == ST_ROUND)
            begin
                pos_x_reg <= sat_pos(sum_x);
                pos_y_reg <= sat_pos(sum_y);
            end
            // Iteration counter
            if (state_reg == ST_VEC || state_reg == ST_ROT)
                cnt_reg <= iter_last ? '0 : cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            // Output register
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tgt_x_reg <= s_tdata[23:0];
            tgt_y_reg <= s_tdata[47:24];
            dt_reg    <= s_tdata[63:48];
        end
        case (state_reg)
            ST_PREP:
            begin
                prod_reg <= PROD_W'(speed_reg) * PROD_W'(dt_reg);
                flip_reg <= dx[CW-1];
                x_reg    <= (dx[CW-1] ? -dx : dx) <<< GUARD;
                y_reg    <= (dx[CW-1] ? -dy : dy) <<< GUARD;
            end
            ST_VEC:
            begin
                dirs_reg[cnt_reg] <= !y_reg[CW-1];
                if (cnt_reg == '0)
                    len_reg <= len_sum[PROD_W:12];
                if (cnt_reg == CNT_W'(1))
                    gain_reg <= scaled[SCL_W-1:GUARD];
                if (iter_last)
                begin
                    x_reg <= CW'(gain_reg);
                    y_reg <= '0;
                end
                else
                begin
                    x_reg <= ux;
                    y_reg <= uy;
                end
            end
            ST_ROT:
            begin
                x_reg <= ux;
                y_reg <= uy;
            end
            ST_FLIP:
                if (flip_reg)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            ST_OUT:
                if (out_free)
                begin
                    out_x_reg <= pos_x_reg;
                    out_y_reg <= pos_y_reg;
                end
            default:
            begin
            end
        endcase
    end

    // Block takes no new item right after accepting one
    assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> !s_tready)
        else $error("input taken while busy");

    // Coincident target leaves the position untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP && zero_vec) |=> (state_reg == ST_OUT
            && $stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("zero vector moved position");

    // Counter starts the vectoring pass at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP && !zero_vec) |=> (cnt_reg == '0))
        else $error("pass started mid-count");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import hts_pkg::*;

    localparam int CORDIC_N = 16;

    // One queued request toward the block
    typedef struct {
        logic              op;
        logic signed [23:0] xv;
        logic signed [23:0] yv;
        logic [15:0]       dt;
    } motion_req_t;

    // Position the block should report
    typedef struct {
        logic [23:0] px;
        logic [23:0] py;
    } pos_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // x_value[23:0], y_value[47:24], time_step[63:48]
    logic [0:0]  s_tuser = '0;     // op[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // out_x[23:0], out_y[47:24]

    // Predictor state
    longint pos_x = 0;
    longint pos_y = 0;
    longint cur_speed = 256;

    motion_req_t pending_reqs[$];
    pos_t        expected_pos[$];

    int  n_in = 0;
    int  n_in_seen = 0;
    int  n_out = 0;
    int  n_cfg = 0;
    int  n_errors = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  in_idle_pct = 0;
    int  out_idle_pct = 0;

    homing_step_toward_target_core #(
        .CORDIC_ITERATIONS(CORDIC_N)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp_pos(longint v);
        if (v > longint'(POS_MAX))
            return longint'(POS_MAX);
        if (v < longint'(POS_MIN))
            return longint'(POS_MIN);
        return v;
    endfunction

    // Constant-speed step toward the target: vectoring pass records the
    // micro-rotation directions, rotation pass turns a step of length
    // speed * dt back to that angle.
    function automatic void advance_position(longint tx, longint ty, longint dt);
        bit [CORDIC_N-1:0] dirs;
        longint dx, dy, vx, vy, sx, sy, step_len, kg;
        bit flip;
        dx = tx - pos_x;
        dy = ty - pos_y;
        if (dx == 0 && dy == 0)
            return;
        kg = longint'(KGAIN);
        step_len = (cur_speed * dt + 2048) >>> 12;
        flip = 0;
        if (dx < 0)
        begin
            dx = -dx;
            dy = -dy;
            flip = 1;
        end
        vx = dx <<< GUARD;
        vy = dy <<< GUARD;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            dirs[i] = (vy >= 0);
            if (dirs[i])
            begin
                vx = vx + sy;
                vy = vy - sx;
            end
            else
            begin
                vx = vx - sy;
                vy = vy + sx;
            end
        end
        vx = (step_len * kg) >>> (16 - GUARD);
        vy = 0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (dirs[i])
            begin
                vx = vx - sy;
                vy = vy + sx;
            end
            else
            begin
                vx = vx + sy;
                vy = vy - sx;
            end
        end
        if (flip)
        begin
            vx = -vx;
            vy = -vy;
        end
        vx = (vx + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
        vy = (vy + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
        pos_x = clamp_pos(pos_x + vx);
        pos_y = clamp_pos(pos_y + vy);
    endfunction

    function automatic void apply_request(logic op, logic signed [23:0] xv,
                                          logic signed [23:0] yv, logic [15:0] dt);
        longint lx, ly, ldt;
        lx = longint'(xv);
        ly = longint'(yv);
        ldt = longint'(dt);
        if (op == OP_LOAD)
        begin
            pos_x = lx;
            pos_y = ly;
        end
        else
            advance_position(lx, ly, ldt);
    endfunction

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Input acceptance: predict from what is on the bus
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            apply_request(s_tuser[0], s_tdata[23:0], s_tdata[47:24], s_tdata[63:48]);
            expected_pos.push_back('{px: pos_x[23:0], py: pos_y[23:0]});
            n_in++;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        pos_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_out++;
            if (expected_pos.size() == 0)
                note_error($sformatf("result with none pending: x=%0d y=%0d",
                                     $signed(m_tdata[23:0]), $signed(m_tdata[47:24])));
            else
            begin
                want = expected_pos.pop_front();
                if (m_tdata[23:0] !== want.px)
                    note_error($sformatf("item %0d out_x: expected %0d, got %0d", n_out,
                                         $signed(want.px), $signed(m_tdata[23:0])));
                if (m_tdata[47:24] !== want.py)
                    note_error($sformatf("item %0d out_y: expected %0d, got %0d", n_out,
                                         $signed(want.py), $signed(m_tdata[47:24])));
            end
        end
    end

    // Input driver, fed from the pending queue
    always @(negedge clk)
    begin
        motion_req_t r;
        logic nv;
        // An item is still waiting unless the acceptance count moved
        nv = s_tvalid && (n_in == n_in_seen);
        n_in_seen = n_in;
        if (!nv && rst_n)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                s_tdata <= {r.dt, r.yv, r.xv};
                s_tuser <= r.op;
                nv = 1'b1;
                if ($urandom_range(0, 99) < in_idle_pct)
                    in_gap = $urandom_range(1, 9);
            end
        end
        s_tvalid <= nv;
    end

    // Output backpressure
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < out_idle_pct)
                out_gap = $urandom_range(1, 9);
        end
    end

    task automatic push_req(input logic op, input logic signed [23:0] xv,
                            input logic signed [23:0] yv, input logic [15:0] dt);
        pending_reqs.push_back('{op: op, xv: xv, yv: yv, dt: dt});
    endtask

    // Block is idle once everything queued has been sent and answered
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_pos.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_speed(input logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_speed = longint'(v);
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_coord();
        int r;
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return POS_MIN;
            2, 3, 4: return 24'($urandom());
            default:
            begin
                r = $urandom_range(0, 262143);
                r = r - 131072;
                return 24'(r);
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(0, 19))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(1, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic int rand_offset();
        int r;
        r = $urandom_range(1, 200000);
        if ($urandom_range(0, 1))
            r = -r;
        return r;
    endfunction

    // Random items: plain loads and advances plus load/advance pairs that
    // hit the equal-target and axis-aligned paths
    task automatic gen_random_items(input int n);
        int k, kind;
        logic signed [23:0] ax, ay, bx, by;
        k = 0;
        while (k < n)
        begin
            kind = $urandom_range(0, 99);
            ax = rand_coord();
            ay = rand_coord();
            if (kind < 15)
            begin
                push_req(OP_LOAD, ax, ay, rand_dt());
                k++;
            end
            else if (kind < 22)
            begin
                push_req(OP_LOAD, ax, ay, rand_dt());
                push_req(OP_ADVANCE, ax, ay, rand_dt());
                k += 2;
            end
            else if (kind < 32)
            begin
                bx = (kind < 27) ? 24'(ax + rand_offset()) : ax;
                by = (kind < 27) ? ay : 24'(ay + rand_offset());
                push_req(OP_LOAD, ax, ay, rand_dt());
                push_req(OP_ADVANCE, bx, by, rand_dt());
                k += 2;
            end
            else
            begin
                push_req(OP_ADVANCE, ax, ay, rand_dt());
                k++;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        logic [15:0] spd;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset speed (1.0)
        push_req(OP_ADVANCE, 24'sd0, 24'sd0, 16'hFFFF);          // target equals position
        push_req(OP_ADVANCE, 24'sd40960, 24'sd0, 16'hFFFF);      // +x axis
        push_req(OP_ADVANCE, -24'sd40960, 24'sd0, 16'hFFFF);     // -x axis
        push_req(OP_LOAD, 24'sd0, 24'sd0, 16'h0000);
        push_req(OP_ADVANCE, 24'sd0, 24'sd40960, 16'hFFFF);      // +y axis
        push_req(OP_ADVANCE, 24'sd0, -24'sd40960, 16'hFFFF);     // -y axis
        push_req(OP_ADVANCE, 24'sd1000, 24'sd1000, 16'h0000);    // zero time step
        push_req(OP_ADVANCE, 24'sd1000, -24'sd1000, 16'h0001);
        push_req(OP_LOAD, 24'sd0, 24'sd0, 16'hFFFF);
        push_req(OP_ADVANCE, 24'sd100, 24'sd50, 16'hFFFF);       // overshoot
        push_req(OP_LOAD, POS_MAX, POS_MAX, 16'h0000);
        push_req(OP_ADVANCE, POS_MIN, POS_MIN, 16'hFFFF);
        push_req(OP_LOAD, POS_MIN, POS_MAX, 16'h0000);
        push_req(OP_ADVANCE, POS_MAX, POS_MIN, 16'h8000);
        push_req(OP_LOAD, POS_MAX - 24'sd10, POS_MIN + 24'sd10, 16'h0000);
        push_req(OP_ADVANCE, POS_MAX, POS_MIN, 16'hFFFF);        // saturate both
        wait_drained();

        // Fastest speed
        write_speed(16'hFFFF);
        push_req(OP_LOAD, 24'sd0, 24'sd0, 16'h0000);
        push_req(OP_ADVANCE, POS_MAX, POS_MAX, 16'hFFFF);
        push_req(OP_LOAD, POS_MAX - 24'sd100, 24'sd0, 16'h0000);
        push_req(OP_ADVANCE, POS_MAX, 24'sd0, 16'hFFFF);
        push_req(OP_ADVANCE, POS_MIN, 24'sd0, 16'hFFFF);
        wait_drained();

        // Zero speed
        write_speed(16'h0000);
        push_req(OP_ADVANCE, 24'sd1000, -24'sd1000, 16'hFFFF);
        push_req(OP_ADVANCE, POS_MIN, POS_MAX, 16'hFFFF);
        wait_drained();

        // Random phases, each at its own speed and idling mix
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: spd = 16'd256;
                1: spd = 16'hFFFF;
                2: spd = 16'h0000;
                3: spd = 16'h0001;
                4: spd = 16'($urandom_range(1, 1024));
                5: spd = 16'h8000;
                default: spd = 16'($urandom());
            endcase
            write_speed(spd);
            if (ph == 8)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct  = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
                out_idle_pct = (ph % 4 == 3) ? 0 : $urandom_range(5, 40);
            end
            gen_random_items(200);
            wait_drained();
        end

        // Catch late or spurious results
        repeat (60) @(posedge clk);
        if (expected_pos.size() > 0)
            note_error($sformatf("%0d results never arrived", expected_pos.size()));
        $display("summary: %0d items sent, %0d results checked, %0d speed writes",
                 n_in, n_out, n_cfg);
        $display("summary: %0d mismatches", n_errors);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== homing_step_toward_target_core.f =====
rtl/hts_pkg.sv
rtl/hts_cordic_unit.sv
rtl/homing_step_toward_target_core.sv
tb/testbench.sv
